// ===== rtl/utf8_stream_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define UFD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ufd assertion failed: same-cycle check");

// next-cycle implication
`define UFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ufd assertion failed: next-cycle check");

`endif

// ===== rtl/ufd_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Queue entry type, byte classification constants and leading-ones counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ufd_pkg;

   // default depth of the front-to-back queue
   localparam int QUEUE_DEPTH = 2;

   // byte classification constants
   localparam logic [7:0] CONT_SEL  = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;
   localparam logic [5:0] CONT_BITS = 6'h3F;
   localparam logic [7:0] FULL_MASK = 8'hFF;

   // classified byte, as handed from front to back
   typedef struct packed {
      logic       start;     // drop partial sequence first
      logic       is_cont;   // 10xxxxxx
      logic [2:0] pend;      // continuation bytes a lead announces
      logic [7:0] value;     // lead value bits; low 6 bits are payload of a continuation
   } entry_type;

   // count of leading ones in a byte, 0 to 8
   function automatic logic [3:0] lead_ones(input logic [7:0] b);
      logic [3:0] n;
      logic       run;
      n   = 4'd0;
      run = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         if (run && b[i]) begin
            n = n + 4'd1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ufd_ifaces.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder channel interfaces
// Valid/ready channels for raw bytes in and decoded code points out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// byte channel
interface ufd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       stream_start;

   modport source (output valid, output byte_in, output stream_start, input ready);
   modport sink   (input valid, input byte_in, input stream_start, output ready);
endinterface

// code point channel
interface ufd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] code_point;
   logic        bad_sequence;

   modport source (output valid, output code_point, output bad_sequence, input ready);
   modport sink   (input valid, input code_point, input bad_sequence, output ready);
endinterface

`default_nettype wire

// ===== rtl/ufd_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder front end
// Accepts bytes and classifies them as continuation or lead with its count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufd_front (
   ufd_req_if.sink             req_chan,
   output logic                push_valid,
   input  logic                push_ready,
   output ufd_pkg::entry_type  push_data
);

   logic [3:0] ones;
   logic [7:0] mask;

   // classify the incoming byte
   always_comb begin
      ones = ufd_pkg::lead_ones(req_chan.byte_in);
      mask = ones[3] ? 8'h00 : (ufd_pkg::FULL_MASK >> ones);
      push_data.start   = req_chan.stream_start;
      push_data.is_cont = (req_chan.byte_in & ufd_pkg::CONT_SEL) == ufd_pkg::CONT_TAG;
      push_data.value   = req_chan.byte_in & mask;
      push_data.pend    = (ones == 4'd0) ? 3'd0 : 3'(ones - 4'd1);
   end

   // handshake passes straight to the queue
   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

`default_nettype wire

// ===== rtl/ufd_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder queue
// Small register FIFO that decouples classification from decoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufd_queue #(
   parameter int DEPTH = ufd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  ufd_pkg::entry_type  push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output ufd_pkg::entry_type  pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ufd_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != FULL_CNT;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ufd_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder back end
// Holds the sequence state, accumulates code points and drives results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_stream_decoder_core_assert.svh"

module ufd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  ufd_pkg::entry_type  pop_data,
   ufd_rsp_if.source           rsp_chan
);

   logic [2:0]  pend_ff, pend_in;
   logic [31:0] accum_ff, accum_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_cp_ff, out_cp_in;
   logic        out_bad_ff, out_bad_in;

   logic [2:0]  pend_cur;
   logic [31:0] accum_cur;
   logic        do_pop;
   logic        emit;
   logic        emit_bad;
   logic [31:0] emit_cp;

   logic        pop_idle_cont;
   logic        pop_last_cont;
   logic        pop_idle_lead;

   // take an entry whenever the output register is free or draining
   assign pop_ready = !out_valid_ff || rsp_chan.ready;
   assign do_pop    = pop_valid && pop_ready;

   // decode step
   always_comb begin
      pend_cur  = pop_data.start ? 3'd0  : pend_ff;
      accum_cur = pop_data.start ? 32'd0 : accum_ff;
      pend_in   = pend_ff;
      accum_in  = accum_ff;
      emit      = 1'b0;
      emit_bad  = 1'b0;
      emit_cp   = 32'd0;
      if (do_pop) begin
         if (pend_cur != 3'd0) begin
            if (!pop_data.is_cont) begin
               // missing continuation: byte consumed, back to idle
               pend_in  = 3'd0;
               accum_in = 32'd0;
               emit     = 1'b1;
               emit_bad = 1'b1;
            end else begin
               accum_in = {accum_cur[25:0], pop_data.value[5:0] & ufd_pkg::CONT_BITS};
               pend_in  = pend_cur - 3'd1;
               if (pend_cur == 3'd1) begin
                  emit    = 1'b1;
                  emit_cp = accum_in;
               end
            end
         end else if (pop_data.is_cont) begin
            // stray continuation while idle
            pend_in  = 3'd0;
            accum_in = 32'd0;
            emit     = 1'b1;
            emit_bad = 1'b1;
         end else begin
            accum_in = {24'd0, pop_data.value};
            pend_in  = pop_data.pend;
            if (pop_data.pend == 3'd0) begin
               emit    = 1'b1;
               emit_cp = accum_in;
            end
         end
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_cp_in    = out_cp_ff;
      out_bad_in   = out_bad_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_cp_in    = emit_cp;
         out_bad_in   = emit_bad;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 3'd0;
         accum_ff     <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         accum_ff     <= accum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_cp_ff  <= out_cp_in;
      out_bad_ff <= out_bad_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.code_point   = out_cp_ff;
   assign rsp_chan.bad_sequence = out_bad_ff;

   // check terms
   assign pop_idle_cont = do_pop && pop_data.is_cont && pend_cur == 3'd0;
   assign pop_last_cont = do_pop && pop_data.is_cont && pend_cur == 3'd1;
   assign pop_idle_lead = do_pop && !pop_data.is_cont && pend_cur == 3'd0;

   // checks
   `UFD_ASSERT_NOW(a_bad_is_zero, out_valid_ff && out_bad_ff, out_cp_ff == 32'd0)
   `UFD_ASSERT_NEXT(a_stray_flags, pop_idle_cont, out_valid_ff && out_bad_ff && pend_ff == 3'd0)
   `UFD_ASSERT_NEXT(a_last_cont_ok, pop_last_cont, out_valid_ff && !out_bad_ff && out_cp_ff == accum_ff)
   `UFD_ASSERT_NEXT(a_lead_loads, pop_idle_lead, pend_ff == $past(pop_data.pend))

endmodule

`default_nettype wire

// ===== rtl/utf8_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core
// Decodes extended UTF-8 (leads of up to seven continuation bytes) per byte.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one raw byte per transaction, with stream_start set on
//   the first byte of a new string to drop any unfinished sequence.
//   rsp_chan carries one code point per completed sequence, or a
//   bad_sequence flag with code point zero for a stray or missing
//   continuation byte. Bytes that only extend a sequence give no result.
//   Throughput is one byte per cycle; the decode unit takes one queue entry
//   per cycle while the output register is free or being drained.
//   The byte that completes a result is first written to a queue slot; the
//   decoder then pops it and the result is held in the output register,
//   which drives rsp_chan.
//   A queue of DEPTH entries sits between the classifier and the decoder.
//   When rsp_chan stalls, the output register holds its transaction, the
//   queue fills and req_chan.ready drops once DEPTH bytes are waiting.
//   Synchronous reset empties the queue, clears the output valid flag and
//   returns the decoder to idle with an empty accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_core #(
   parameter int DEPTH = ufd_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   ufd_req_if.sink     req_chan,
   ufd_rsp_if.source   rsp_chan
);

   logic               push_valid, push_ready;
   ufd_pkg::entry_type push_data;
   logic               pop_valid, pop_ready;
   ufd_pkg::entry_type pop_data;

   // classify incoming bytes
   ufd_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decoupling queue
   ufd_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // sequence decode and result register
   ufd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
